### hw/rtl/fpm_pkg.sv
`default_nettype none
package fpm_pkg;

  localparam int unsigned RING_DEPTH_DEF = 64;
  localparam logic [31:0] IDLE_CUTOFF_RST = 32'd250000;
  localparam int unsigned CFG_AW = 3;

  // floor(x*19/20) as (x*P95_MUL) >> P95_SHIFT, exact for x below 256
  localparam int unsigned P95_SHIFT = 16;
  localparam logic [15:0] P95_MUL = 16'd62263;

  localparam logic CMD_FLUSH = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic REG_IDLE_CUTOFF = 1'b0;

  typedef struct packed {
    logic        command;
    logic [62:0] time_us;
    logic [31:0] write_us;
    logic [31:0] payload_len;
  } in_word_t;

  typedef struct packed {
    logic [31:0] gap_p95;
    logic [31:0] gap_max;
    logic [31:0] write_mean;
    logic [31:0] write_peak;
    logic [63:0] total_bytes;
    logic [31:0] total_frames;
  } out_word_t;

endpackage
`default_nettype wire

### hw/rtl/fpm_ring_ram.sv
`default_nettype none
module fpm_ring_ram #(
  parameter int unsigned DEPTH = fpm_pkg::RING_DEPTH_DEF,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/fpm_div.sv
`default_nettype none
module fpm_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient
);

  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [32:0] trial;

  always_comb begin
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    trial   = {rem_r[31:0], quo_r[63]};
    if (start) begin
      cnt_nxt = 7'd64;
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != 7'd0) begin
      cnt_nxt = cnt_r - 7'd1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy     = (cnt_r != 7'd0);
  assign quotient = quo_r[31:0];

endmodule
`default_nettype wire

### hw/rtl/frame_pacing_monitor.sv
`default_nettype none
// Frame pacing monitor. A flush word is answered in the cycle after it is taken; its
// result word carries the running byte and frame totals. A statistics read ranks the
// filled ring entries by counting against a ring memory with one read port: each of
// the n entries is read once as a candidate and then compared with all n entries, and
// the result word of a read also waits for the 64-step mean divider to finish. The
// input stalls while a read is in progress or a result is still held.
module frame_pacing_monitor #(
  parameter int unsigned RING_DEPTH = fpm_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire fpm_pkg::in_word_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output fpm_pkg::out_word_t                 out_data,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [fpm_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic      [31:0]                   cfg_prdata,
  output logic                               cfg_pready
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned KW = CW + 16;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_CRD  = 3'd2;
  localparam logic [2:0] S_CLAT = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_EVAL = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [31:0]   cutoff_r;
  logic [62:0]   prev_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] fill_r;
  logic [63:0]   wsum_r;
  logic [31:0]   wmax_r;
  logic [31:0]   wcnt_r;
  logic [63:0]   bytes_r;
  logic [31:0]   frames_r;
  logic          ovalid_r;
  fpm_pkg::out_word_t odata_r;

  logic [CW-1:0] k_r, lt_r, le_r, nm1;
  logic [AW-1:0] cand_idx_r, scan_idx_r;
  logic [31:0]   cand_r, p95_r, gmax_r;

  logic          accept, out_free, cfg_wr;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic [63:0]   gap_full;
  logic [31:0]   gap;
  logic          div_start, div_busy;
  logic [31:0]   div_q;
  logic [KW-1:0] k_prod;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cutoff_r;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[2] == fpm_pkg::REG_IDLE_CUTOFF);

  assign out_free  = !ovalid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  assign gap_full = {1'b0, in_data.time_us} - {1'b0, prev_r};
  assign gap      = gap_full[31:0];
  assign ram_we   = accept && (in_data.command == fpm_pkg::CMD_FLUSH) &&
                    (in_data.payload_len != 32'd0) && (prev_r != 63'd0) && (gap <= cutoff_r);
  assign nm1      = fill_r - CW'(1);
  assign k_prod   = KW'(nm1) * KW'(fpm_pkg::P95_MUL);
  assign div_start = (state_r == S_PREP);

  always_comb begin
    unique case (state_r)
      S_CRD:   ram_raddr = cand_idx_r;
      S_CLAT:  ram_raddr = '0;
      default: ram_raddr = scan_idx_r + AW'(1);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && in_data.command == fpm_pkg::CMD_READ) state_nxt = S_PREP;
      S_PREP: state_nxt = (fill_r == '0) ? S_DONE : S_CRD;
      S_CRD:  state_nxt = S_CLAT;
      S_CLAT: state_nxt = S_SCAN;
      S_SCAN: if (CW'(scan_idx_r) == nm1) state_nxt = S_EVAL;
      S_EVAL: state_nxt = (CW'(cand_idx_r) == nm1) ? S_DONE : S_CRD;
      S_DONE: if (!div_busy && out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  fpm_ring_ram #(.DEPTH(RING_DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (gap),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fpm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (wsum_r),
    .divisor  (wcnt_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cutoff_r <= fpm_pkg::IDLE_CUTOFF_RST;
      prev_r   <= '0;
      head_r   <= '0;
      fill_r   <= '0;
      wsum_r   <= '0;
      wmax_r   <= '0;
      wcnt_r   <= '0;
      bytes_r  <= '0;
      frames_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        cutoff_r <= cfg_pwdata;
      end
      if ((accept && in_data.command == fpm_pkg::CMD_FLUSH) ||
          (state_r == S_DONE && !div_busy && out_free)) begin
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
      if (accept && in_data.command == fpm_pkg::CMD_FLUSH) begin
        if (in_data.payload_len != 32'd0) begin
          prev_r   <= in_data.time_us;
          wsum_r   <= wsum_r + 64'(in_data.write_us);
          wcnt_r   <= wcnt_r + 32'd1;
          if (in_data.write_us > wmax_r) wmax_r <= in_data.write_us;
          bytes_r  <= bytes_r + 64'(in_data.payload_len);
          frames_r <= frames_r + 32'd1;
        end
        if (ram_we) begin
          head_r <= (32'(head_r) == RING_DEPTH - 1) ? '0 : head_r + AW'(1);
          if (32'(fill_r) < RING_DEPTH) fill_r <= fill_r + CW'(1);
        end
      end
      if (state_r == S_DONE && !div_busy && out_free) begin
        wsum_r   <= '0;
        wcnt_r   <= '0;
        wmax_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.command == fpm_pkg::CMD_FLUSH) begin
      odata_r.gap_p95      <= '0;
      odata_r.gap_max      <= '0;
      odata_r.write_mean   <= '0;
      odata_r.write_peak   <= '0;
      odata_r.total_bytes  <= (in_data.payload_len != 32'd0) ?
                              bytes_r + 64'(in_data.payload_len) : bytes_r;
      odata_r.total_frames <= (in_data.payload_len != 32'd0) ? frames_r + 32'd1 : frames_r;
    end
    if (state_r == S_DONE && !div_busy && out_free) begin
      odata_r.gap_p95      <= p95_r;
      odata_r.gap_max      <= gmax_r;
      odata_r.write_mean   <= (wcnt_r == 32'd0) ? 32'd0 : div_q;
      odata_r.write_peak   <= wmax_r;
      odata_r.total_bytes  <= bytes_r;
      odata_r.total_frames <= frames_r;
    end
    case (state_r)
      S_PREP: begin
        k_r        <= k_prod[KW-1:fpm_pkg::P95_SHIFT];
        cand_idx_r <= '0;
        p95_r      <= '0;
        gmax_r     <= '0;
      end
      S_CLAT: begin
        cand_r     <= ram_rdata;
        scan_idx_r <= '0;
        lt_r       <= '0;
        le_r       <= '0;
      end
      S_SCAN: begin
        if (ram_rdata < cand_r) lt_r <= lt_r + CW'(1);
        if (ram_rdata <= cand_r) le_r <= le_r + CW'(1);
        scan_idx_r <= scan_idx_r + AW'(1);
      end
      S_EVAL: begin
        if (lt_r <= k_r && k_r < le_r) p95_r <= cand_r;
        if (lt_r <= nm1 && nm1 < le_r) gmax_r <= cand_r;
        cand_idx_r <= cand_idx_r + AW'(1);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING = fpm_pkg::RING_DEPTH_DEF;
  localparam logic [fpm_pkg::CFG_AW-1:0] ADDR_IDLE_CUTOFF =
    fpm_pkg::CFG_AW'(fpm_pkg::REG_IDLE_CUTOFF) << 2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fpm_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fpm_pkg::out_word_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [fpm_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  frame_pacing_monitor i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // pacing state mirror
  logic [31:0] cutoff_q;
  logic [62:0] last_flush_q;
  logic [31:0] gaps_q [RING];
  int unsigned head_q, fill_q;
  logic [63:0] wsum_q;
  logic [31:0] wpeak_q, wcount_q, frames_q;
  logic [63:0] bytes_q;

  fpm_pkg::out_word_t pending_stats [$];
  int unsigned fails = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit hold_off = 1'b0;
  logic [62:0] clock_us;

  function automatic fpm_pkg::out_word_t pace_stats(fpm_pkg::in_word_t w);
    fpm_pkg::out_word_t r;
    logic [31:0] gap, key;
    logic [31:0] srt [RING];
    int unsigned n, i, j;
    r = '0;
    if (w.command == fpm_pkg::CMD_FLUSH) begin
      if (w.payload_len != 0) begin
        if (last_flush_q != 0) begin
          gap = 32'(w.time_us - last_flush_q);
          if (gap <= cutoff_q) begin
            gaps_q[head_q] = gap;
            head_q = (head_q + 1) % RING;
            if (fill_q < RING) fill_q++;
          end
        end
        last_flush_q = w.time_us;
        wsum_q += 64'(w.write_us);
        wcount_q++;
        if (w.write_us > wpeak_q) wpeak_q = w.write_us;
        bytes_q += 64'(w.payload_len);
        frames_q++;
      end
    end else begin
      n = fill_q;
      if (n > 0) begin
        for (i = 0; i < n; i++) srt[i] = gaps_q[i];
        for (i = 1; i < n; i++) begin
          key = srt[i];
          j = i;
          while (j > 0 && srt[j-1] > key) begin
            srt[j] = srt[j-1];
            j--;
          end
          srt[j] = key;
        end
        r.gap_p95 = srt[((n - 1) * 19) / 20];
        r.gap_max = srt[n-1];
      end
      r.write_mean = (wcount_q != 0) ? 32'(wsum_q / 64'(wcount_q)) : 32'd0;
      r.write_peak = wpeak_q;
      wsum_q = '0;
      wcount_q = '0;
      wpeak_q = '0;
    end
    r.total_bytes = bytes_q;
    r.total_frames = frames_q;
    return r;
  endfunction

  task automatic send_word(fpm_pkg::in_word_t w);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_stats.push_back(pace_stats(w));
  endtask

  task automatic send_flush(logic [62:0] t, logic [31:0] wr, logic [31:0] len);
    fpm_pkg::in_word_t w;
    w.command = fpm_pkg::CMD_FLUSH;
    w.time_us = t;
    w.write_us = wr;
    w.payload_len = len;
    send_word(w);
  endtask

  task automatic send_read();
    fpm_pkg::in_word_t w;
    w.command = fpm_pkg::CMD_READ;
    w.time_us = 63'({$urandom, $urandom});
    w.write_us = $urandom;
    w.payload_len = $urandom;
    send_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cutoff(logic [31:0] v);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_IDLE_CUTOFF;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cutoff_q = v;
    @(posedge clk);
  endtask

  // random flush with well-formed pacing, most gaps small
  task automatic paced_flush();
    logic [31:0] step;
    case ($urandom_range(9))
      0: step = $urandom;
      1: step = $urandom_range(300000, 200000);
      default: step = $urandom_range(40000);
    endcase
    clock_us = clock_us + 63'(step);
    send_flush(clock_us, ($urandom_range(3) == 0) ? $urandom : $urandom_range(20000),
               ($urandom_range(15) == 0) ? 32'd0 : $urandom);
  endtask

  task automatic test_directed();
    send_read();
    send_flush(63'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_flush(63'd1000, 32'd0, 32'd1);
    send_flush(63'd5000, 32'd7, 32'd0);
    send_flush(63'd2000, 32'd3, 32'd10);
    send_flush(63'd252000, 32'd5, 32'hFFFF_FFFF);
    send_flush(63'd502001, 32'd9, 32'd100);
    send_read();
    send_read();
    send_flush({1'b1, 62'h0}, 32'h8000_0000, 32'h8000_0000);
    send_flush({63{1'b1}}, 32'h8000_0000, 32'h5555_5555);
    send_flush(63'h2AAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    send_flush(63'h0000_0000_0001_0000, 32'h5555_5555, 32'h1234_5678);
    send_read();
  endtask

  task automatic test_cutoff_extremes();
    write_cutoff(32'd0);
    send_flush(63'd10, 32'd1, 32'd1);
    send_flush(63'd10, 32'd2, 32'd1);
    send_flush(63'd11, 32'd3, 32'd1);
    send_read();
    write_cutoff(32'hFFFF_FFFF);
    send_flush(63'h1_0000_0010, 32'd4, 32'd2);
    send_flush(63'h1_FFFF_FFFF, 32'd4, 32'd2);
    send_read();
  endtask

  task automatic test_ring_wrap();
    int unsigned k;
    clock_us = 63'd1000;
    write_cutoff(fpm_pkg::IDLE_CUTOFF_RST);
    for (k = 0; k < 70; k++) begin
      clock_us = clock_us + 63'($urandom_range(3000));
      send_flush(clock_us, $urandom_range(100), 32'd1 + $urandom_range(9));
    end
    send_read();
  endtask

  task automatic test_random(int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(9) == 0) send_read();
      else paced_flush();
    end
    send_read();
  endtask

  task automatic test_backpressure();
    int unsigned k;
    hold_off = 1'b1;
    for (k = 0; k < 6; k++) paced_flush();
    send_read();
    drain();
    hold_off = 1'b0;
  endtask

  always @(posedge clk) begin
    fpm_pkg::out_word_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        exp = pending_stats.pop_front();
        if (out_data.gap_p95 !== exp.gap_p95) begin
          $error("gap_p95 exp %0d got %0d", exp.gap_p95, out_data.gap_p95); fails++;
        end
        if (out_data.gap_max !== exp.gap_max) begin
          $error("gap_max exp %0d got %0d", exp.gap_max, out_data.gap_max); fails++;
        end
        if (out_data.write_mean !== exp.write_mean) begin
          $error("write_mean exp %0d got %0d", exp.write_mean, out_data.write_mean); fails++;
        end
        if (out_data.write_peak !== exp.write_peak) begin
          $error("write_peak exp %0d got %0d", exp.write_peak, out_data.write_peak); fails++;
        end
        if (out_data.total_bytes !== exp.total_bytes) begin
          $error("total_bytes exp %0d got %0d", exp.total_bytes, out_data.total_bytes);
          fails++;
        end
        if (out_data.total_frames !== exp.total_frames) begin
          $error("total_frames exp %0d got %0d", exp.total_frames, out_data.total_frames);
          fails++;
        end
      end
    end
  end

  // receiver stall, with a long counted hold-off when asked
  always @(posedge clk) begin
    int unsigned held;
    if (hold_off && held < 300) begin
      out_stall <= 1'b1;
      held++;
    end else begin
      if (!hold_off) held = 0;
      out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    cutoff_q = fpm_pkg::IDLE_CUTOFF_RST;
    last_flush_q = '0;
    for (int i = 0; i < RING; i++) gaps_q[i] = '0;
    head_q = 0;
    fill_q = 0;
    wsum_q = '0;
    wpeak_q = '0;
    wcount_q = '0;
    bytes_q = '0;
    frames_q = '0;
    clock_us = 63'd1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 23;
    recv_idle_pct = 73;
    test_directed();
    test_cutoff_extremes();
    test_ring_wrap();
    send_idle_pct = 73;
    recv_idle_pct = 23;
    write_cutoff(32'd30000);
    test_random(20);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    write_cutoff(fpm_pkg::IDLE_CUTOFF_RST);
    test_random(25);
    drain();
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
